FILE: rtl/cnnmt_pkg.sv
// Shared types, state and event codes, and the transition table for the NMT state machine.
package cnnmt_pkg;

  localparam int EVENT_W = 5;
  localparam int STATE_W = 4;

  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [STATE_W-1:0] state_t;

  // Result of one event
  typedef struct packed {
    state_t node_state;
    logic   accepted;
    logic   manager_enabled;
    logic   application_entered;
  } result_t;

  // Node states
  localparam state_t ST_OFFLINE     = 4'd0;
  localparam state_t ST_INIT        = 4'd1;
  localparam state_t ST_RESET_APP   = 4'd2;
  localparam state_t ST_RESET_COM   = 4'd3;
  localparam state_t ST_RESET_CFG   = 4'd4;
  localparam state_t ST_NOT_ACTIVE  = 4'd5;
  localparam state_t ST_BASIC_ETH   = 4'd6;
  localparam state_t ST_PREOP1      = 4'd7;
  localparam state_t ST_PREOP2      = 4'd8;
  localparam state_t ST_RTO         = 4'd9;
  localparam state_t ST_OPERATIONAL = 4'd10;
  localparam state_t ST_STOPPED     = 4'd11;

  // Events that the table uses
  localparam event_t EV_SW_RESET       = 5'd0;
  localparam event_t EV_START_UP       = 5'd1;
  localparam event_t EV_SWITCH_ON      = 5'd3;
  localparam event_t EV_TO_PREOP1      = 5'd4;
  localparam event_t EV_TO_PREOP2      = 5'd5;
  localparam event_t EV_TO_RTO         = 5'd6;
  localparam event_t EV_TO_OPERATIONAL = 5'd7;
  localparam event_t EV_REQ_RESET_APP  = 5'd9;
  localparam event_t EV_REQ_RESET_COM  = 5'd10;
  localparam event_t EV_REQ_RESET_CFG  = 5'd11;
  localparam event_t EV_APP_ENTER_RTO  = 5'd12;
  localparam event_t EV_STOP_NODE      = 5'd13;
  localparam event_t EV_INT_RESET_APP  = 5'd14;
  localparam event_t EV_INT_RESET_COM  = 5'd15;
  localparam event_t EV_INT_RESET_CFG  = 5'd16;
  localparam event_t EV_RECV_SOC       = 5'd21;
  localparam event_t EV_RECV_SOA       = 5'd22;
  localparam event_t EV_MN_ENABLE_RTO  = 5'd23;
  localparam event_t EV_START_NODE     = 5'd25;
  localparam event_t EV_RESYNC         = 5'd26;

  // Fixed transition table; an unlisted event keeps the state
  function automatic state_t next_state(input state_t s, input event_t e);
    state_t ns;
    ns = s;
    case (s)
      ST_OFFLINE: begin
        if (e inside {EV_SW_RESET, EV_START_UP, EV_SWITCH_ON, EV_REQ_RESET_APP,
                      EV_REQ_RESET_COM, EV_REQ_RESET_CFG})
          ns = ST_INIT;
      end
      ST_INIT: begin
        if (e inside {EV_SWITCH_ON, EV_INT_RESET_APP, EV_REQ_RESET_APP})
          ns = ST_RESET_APP;
      end
      ST_RESET_APP: begin
        if (e inside {EV_INT_RESET_COM, EV_REQ_RESET_COM}) ns = ST_RESET_COM;
      end
      ST_RESET_COM: begin
        if (e inside {EV_INT_RESET_CFG, EV_REQ_RESET_CFG}) ns = ST_RESET_CFG;
      end
      ST_RESET_CFG: begin
        if (e inside {EV_INT_RESET_APP, EV_SWITCH_ON}) ns = ST_NOT_ACTIVE;
      end
      ST_NOT_ACTIVE: begin
        if (e == EV_RECV_SOC) ns = ST_PREOP1;
        else if (e == EV_RECV_SOA) ns = ST_BASIC_ETH;
      end
      ST_BASIC_ETH: begin
        if (e == EV_RECV_SOC) ns = ST_PREOP1;
      end
      ST_PREOP1: begin
        if (e inside {EV_RECV_SOC, EV_TO_PREOP2}) ns = ST_PREOP2;
      end
      ST_PREOP2: begin
        if (e == EV_APP_ENTER_RTO) ns = ST_RTO;
        else if (e inside {EV_TO_OPERATIONAL, EV_START_NODE}) ns = ST_OPERATIONAL;
        else if (e == EV_TO_PREOP1) ns = ST_PREOP1;
      end
      ST_RTO: begin
        if (e inside {EV_TO_OPERATIONAL, EV_START_NODE}) ns = ST_OPERATIONAL;
        else if (e == EV_TO_PREOP2) ns = ST_PREOP2;
        else if (e == EV_TO_PREOP1) ns = ST_PREOP1;
        else if (e == EV_STOP_NODE) ns = ST_STOPPED;
      end
      ST_OPERATIONAL: begin
        if (e == EV_STOP_NODE) ns = ST_STOPPED;
        else if (e == EV_TO_PREOP2) ns = ST_PREOP2;
        else if (e == EV_TO_PREOP1) ns = ST_PREOP1;
        else if (e == EV_TO_RTO) ns = ST_RTO;
      end
      ST_STOPPED: begin
        if (e inside {EV_START_NODE, EV_RESYNC}) ns = ST_OPERATIONAL;
        else if (e == EV_TO_PREOP2) ns = ST_PREOP2;
        else if (e == EV_TO_PREOP1) ns = ST_PREOP1;
        else if (e == EV_TO_RTO) ns = ST_RTO;
      end
      default: ns = s;
    endcase
    // Reset requests override in every state from not-active upward
    if (s >= ST_NOT_ACTIVE && s <= ST_STOPPED) begin
      if (e == EV_REQ_RESET_APP) ns = ST_RESET_APP;
      else if (e == EV_REQ_RESET_COM) ns = ST_RESET_COM;
      else if (e == EV_REQ_RESET_CFG) ns = ST_RESET_CFG;
      else if (e == EV_SW_RESET) ns = ST_INIT;
    end
    return ns;
  endfunction

endpackage

FILE: rtl/cnnmt_ifs.sv
// Valid/ready channel interfaces for the event input and the result output.
interface cnnmt_evt_if;
  import cnnmt_pkg::*;

  logic   valid;
  logic   ready;
  event_t event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

interface cnnmt_res_if;
  import cnnmt_pkg::*;

  logic   valid;
  logic   ready;
  state_t node_state;
  logic   accepted;
  logic   manager_enabled;
  logic   application_entered;

  modport source (output valid, output node_state, output accepted,
                  output manager_enabled, output application_entered, input ready);
  modport sink (input valid, input node_state, input accepted,
                input manager_enabled, input application_entered, output ready);
endinterface

FILE: rtl/cnnmt_in_reg.sv
// Input register stage: holds one event until the core consumes it.
module cnnmt_in_reg (
  input  logic              clk,
  input  logic              rst,
  cnnmt_evt_if.sink         events,
  input  logic              advance,
  output logic              item_valid,
  output cnnmt_pkg::event_t item_code
);
  import cnnmt_pkg::*;

  // Take a new transfer whenever the slot is empty or drains this cycle
  assign events.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (events.ready) begin
      item_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      item_code <= events.event_code;
    end
  end

endmodule

FILE: rtl/cnnmt_core.sv
// Node state and handshake flags, updated by one event per cycle while advance is high.
module cnnmt_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  cnnmt_pkg::event_t  item_code,
  output cnnmt_pkg::result_t result
);
  import cnnmt_pkg::*;

  state_t current_state;
  state_t current_state_next;
  logic   manager_ready;
  logic   manager_ready_next;
  logic   application_ready;
  logic   application_ready_next;
  logic   handshake;
  logic   accepted_next;
  state_t table_state;

  assign handshake   = (item_code == EV_MN_ENABLE_RTO) || (item_code == EV_APP_ENTER_RTO);
  assign table_state = next_state(current_state, item_code);

  // Flag update, then either the handshake gate or the table
  always_comb begin
    manager_ready_next     = manager_ready || (item_code == EV_MN_ENABLE_RTO);
    application_ready_next = application_ready || (item_code == EV_APP_ENTER_RTO);
    current_state_next     = current_state;
    accepted_next          = 1'b0;
    if (current_state == ST_PREOP2 && handshake) begin
      if (manager_ready_next && application_ready_next) begin
        current_state_next = ST_RTO;
        accepted_next      = 1'b1;
      end
    end else if (table_state != current_state) begin
      current_state_next = table_state;
      accepted_next      = 1'b1;
      // Initialising and the reset states drop both flags
      if (table_state >= ST_INIT && table_state <= ST_RESET_CFG) begin
        manager_ready_next     = 1'b0;
        application_ready_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state     <= ST_OFFLINE;
      manager_ready     <= 1'b0;
      application_ready <= 1'b0;
    end else if (advance) begin
      current_state     <= current_state_next;
      manager_ready     <= manager_ready_next;
      application_ready <= application_ready_next;
    end
  end

  assign result = '{node_state:          current_state_next,
                    accepted:            accepted_next,
                    manager_enabled:     manager_ready_next,
                    application_entered: application_ready_next};

endmodule

FILE: rtl/cnnmt_out_reg.sv
// Result register: holds one result until the downstream transfer completes.
module cnnmt_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  cnnmt_pkg::result_t result_next,
  cnnmt_res_if.source        results,
  output logic               stall
);
  import cnnmt_pkg::*;

  logic    out_valid;
  result_t result;

  // Full and not taken this cycle
  assign stall = out_valid && !results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign results.valid               = out_valid;
  assign results.node_state          = result.node_state;
  assign results.accepted            = result.accepted;
  assign results.manager_enabled     = result.manager_enabled;
  assign results.application_entered = result.application_entered;

endmodule

FILE: rtl/controlled_node_nmt_state_machine.sv
// Top level of the controlled-node NMT state machine.
// Takes one NMT event per transfer on the events channel and returns one result per
// event on the results channel: the node state after the event, whether the state
// changed, and the manager-enabled and application-entered ready-to-operate flags.
// An event passes through an input register, a single pass of table and flag logic
// that updates the state, and a result register. Its result is offered from the result
// register once the held event is processed, which waits while that register stalls. One
// event is taken every cycle as long as results are taken.
// After reset the node is offline with both flags clear.
module controlled_node_nmt_state_machine (
  input  logic        clk,
  input  logic        rst,
  cnnmt_evt_if.sink   events,
  cnnmt_res_if.source results
);
  import cnnmt_pkg::*;

  logic    item_valid;
  event_t  item_code;
  logic    advance;
  logic    stall;
  result_t result_next;

  // Process the held event whenever the result register can take its result
  assign advance = item_valid && !stall;

  cnnmt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .events     (events),
    .advance    (advance),
    .item_valid (item_valid),
    .item_code  (item_code)
  );

  cnnmt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item_code (item_code),
    .result    (result_next)
  );

  cnnmt_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .result_next (result_next),
    .results     (results),
    .stall       (stall)
  );

endmodule
